@@ hw/rtl/slrg_pkg.sv @@
// slrg_pkg: shared constants and types for the shuffled lehmer generator
// no dependencies; imported by slrg_lehmer, the top level and the testbench
package slrg_pkg;

   localparam int VALUE_W     = 31;
   // table depth is a power of two, so the slot divisor is a power of two too
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   localparam int MUL_W = 15;
   localparam logic [MUL_W-1:0]   LEHMER_MUL = MUL_W'(16807);
   localparam logic [VALUE_W-1:0] LEHMER_MOD = VALUE_W'(2147483647);
   localparam logic [VALUE_W-1:0] SAMPLE_CAP = VALUE_W'(2147483389);

   localparam longint SLOT_DIV   = 1 + (2147483647 - 1) / TABLE_DEPTH;
   localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);

   localparam int WARMUP_STEPS = 8;
   localparam int INIT_STEPS   = TABLE_DEPTH + WARMUP_STEPS;
   localparam int STEP_CNT_W   = $clog2(INIT_STEPS);

   // request function codes
   localparam logic FUNC_DRAW   = 1'b0;
   localparam logic FUNC_RESEED = 1'b1;

   typedef logic [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic      done;
      value_type value;
   } lehmer_rsp_type;

endpackage

@@ hw/rtl/slrg_lehmer.sv @@
// slrg_lehmer: one park-miller step, x * 16807 mod (2^31 - 1), in two stages
// depends on slrg_pkg; stage one multiplies, stage two folds the mersenne modulus
module slrg_lehmer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  slrg_pkg::value_type       x,
   output slrg_pkg::lehmer_rsp_type  rsp
);
   import slrg_pkg::*;

   localparam int PROD_W = VALUE_W + MUL_W;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               prod_valid_ff;
   value_type          res_ff, res_in;
   logic               done_ff;
   logic [VALUE_W:0]   fold_sum;

   assign prod_in = PROD_W'(x) * PROD_W'(LEHMER_MUL);

   // 2^31 = 1 mod m, so hi + lo needs at most one subtract of m
   always_comb begin
      fold_sum = {1'b0, prod_ff[VALUE_W-1:0]}
               + (VALUE_W+1)'(prod_ff[PROD_W-1:VALUE_W]);
      if (fold_sum >= {1'b0, LEHMER_MOD}) begin
         res_in = VALUE_W'(fold_sum - {1'b0, LEHMER_MOD});
      end else begin
         res_in = fold_sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         prod_valid_ff <= start;
         done_ff       <= prod_valid_ff;
      end
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

@@ hw/rtl/slrg_table_ram.sv @@
// slrg_table_ram: generic single-write, single-read synchronous ram
// no dependencies; read data is registered and held between reads
module slrg_table_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/shuffled_lehmer_random_generator_top.sv @@
// shuffled_lehmer_random_generator_top: park-miller generator with bays-durham shuffle
// depends on slrg_pkg, slrg_lehmer and slrg_table_ram
//
// A plain draw reads the shuffle table and starts the generator step in S_DRAW, waits
// in S_DRAWW for the pipelined multiply and modulus fold unit, then in S_FIN writes the
// slot back and loads the result register; the next request is taken only back in idle.
// A reseed (and the first draw after reset, which seeds with 1) first runs 40 generator
// steps through the same unit, filling the table on the last 32. A result waiting in
// the output register does not stop a new request from being taken; only the
// write-back cycle waits for it.
// The table needs no clearing after reset, since it is always filled before use.
module shuffled_lehmer_random_generator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [slrg_pkg::VALUE_W-1:0] req_seed,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [slrg_pkg::VALUE_W-1:0] rsp_sample
);
   import slrg_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_STEP  = 3'd1;
   localparam logic [2:0] S_STEPW = 3'd2;
   localparam logic [2:0] S_DRAW  = 3'd3;
   localparam logic [2:0] S_DRAWW = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0]            state_ff, state_in;
   value_type             gen_ff, gen_in;
   value_type             pick_ff, pick_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   value_type             rsp_sample_ff, rsp_sample_in;

   logic                  lm_start;
   lehmer_rsp_type        lm_rsp;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   value_type             wr_data;
   logic                  rd_en;
   value_type             rd_data;

   value_type             slot_wide;
   logic [IDX_W-1:0]      slot_sel;

   slrg_lehmer u_lehmer (
      .clock (clock),
      .reset (reset),
      .start (lm_start),
      .x     (gen_ff),
      .rsp   (lm_rsp)
   );

   slrg_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (VALUE_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot_sel),
      .rd_data (rd_data)
   );

   // slot divisor is a power of two, so the divide is a shift
   always_comb begin
      slot_wide = pick_ff >> SLOT_SHIFT;
      if (slot_wide >= VALUE_W'(TABLE_DEPTH)) begin
         slot_sel = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         slot_sel = slot_wide[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      gen_in        = gen_ff;
      pick_in       = pick_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      lm_start      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      wr_data       = lm_rsp.value;
      rd_en         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // on a draw, a zero last pick forces a seed-1 initialisation
               if (req_func == FUNC_RESEED || pick_ff == '0) begin
                  if (req_func == FUNC_RESEED && req_seed != '0) begin
                     gen_in = req_seed;
                  end else begin
                     gen_in = VALUE_W'(1);
                  end
                  cnt_in   = STEP_CNT_W'(INIT_STEPS - 1);
                  state_in = S_STEP;
               end else begin
                  state_in = S_DRAW;
               end
            end
         end
         S_STEP: begin
            lm_start = 1'b1;
            state_in = S_STEPW;
         end
         S_STEPW: begin
            if (lm_rsp.done) begin
               gen_in = lm_rsp.value;
               if (cnt_ff < STEP_CNT_W'(TABLE_DEPTH)) begin
                  wr_en = 1'b1;
               end
               if (cnt_ff == '0) begin
                  pick_in  = lm_rsp.value;
                  state_in = S_DRAW;
               end else begin
                  cnt_in   = cnt_ff - STEP_CNT_W'(1);
                  state_in = S_STEP;
               end
            end
         end
         S_DRAW: begin
            lm_start = 1'b1;
            rd_en    = 1'b1;
            slot_in  = slot_sel;
            state_in = S_DRAWW;
         end
         S_DRAWW: begin
            if (lm_rsp.done) begin
               gen_in   = lm_rsp.value;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold the write-back until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               wr_en        = 1'b1;
               wr_addr      = slot_ff;
               wr_data      = gen_ff;
               pick_in      = rd_data;
               rsp_valid_in = 1'b1;
               if (rd_data > SAMPLE_CAP) begin
                  rsp_sample_in = SAMPLE_CAP;
               end else begin
                  rsp_sample_in = rd_data;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= VALUE_W'(1);
         pick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         pick_ff      <= pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      lm_rsp.done |-> (state_ff == S_STEPW || state_ff == S_DRAWW))
      else $error("generator step finished outside a wait state");

   a_value_reduced: assert property (@(posedge clock) disable iff (reset)
      lm_rsp.done |-> lm_rsp.value < LEHMER_MOD)
      else $error("generator value not reduced below modulus");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result loaded outside write-back");

   a_sample_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff <= SAMPLE_CAP)
      else $error("sample above cap");

   a_start_one_cycle: assert property (@(posedge clock) disable iff (reset)
      lm_start |=> !lm_start)
      else $error("generator started on back-to-back cycles");
`endif

endmodule

@@ tb/slrg_draw_checker.sv @@
// slrg_draw_checker: watches the request and sample channels of the shuffled lehmer generator,
// predicts every sample from its own copy of the generator and shuffle table, and counts failures
// depends on slrg_pkg for widths and constants
module slrg_draw_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_func,
   input  slrg_pkg::value_type req_seed,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  slrg_pkg::value_type rsp_sample,
   output int                  mismatches,
   output int                  samples_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import slrg_pkg::*;

   localparam int   REPORT_MAX  = 10;

   value_type generator_state;
   value_type shuffle_store [TABLE_DEPTH];
   value_type last_pick;
   value_type expected_samples [$];

   function automatic value_type lehmer_advance(value_type x);
      logic [63:0] product;
      product = 64'(x) * 64'(LEHMER_MUL);
      return value_type'(product % 64'(LEHMER_MOD));
   endfunction

   // warm-up steps are dropped, the last TABLE_DEPTH steps fill the table top down
   function automatic void fill_shuffle_store(value_type seed_value);
      generator_state = seed_value;
      for (int i = TABLE_DEPTH + WARMUP_STEPS - 1; i >= 0; i--) begin
         generator_state = lehmer_advance(generator_state);
         if (i < TABLE_DEPTH)
            shuffle_store[i] = generator_state;
      end
      last_pick = shuffle_store[0];
   endfunction

   function automatic value_type draw_sample(logic func, value_type seed_value);
      longint slot;
      if (func == FUNC_RESEED)
         fill_shuffle_store(seed_value != '0 ? seed_value : value_type'(1));
      else if (last_pick == '0)
         fill_shuffle_store(value_type'(1));
      generator_state = lehmer_advance(generator_state);
      slot = longint'(last_pick) / SLOT_DIV;
      if (slot >= TABLE_DEPTH)
         slot = TABLE_DEPTH - 1;
      last_pick = shuffle_store[slot];
      shuffle_store[slot] = generator_state;
      return (last_pick > SAMPLE_CAP) ? SAMPLE_CAP : last_pick;
   endfunction

   task automatic log_failure(string what);
      if (mismatches < REPORT_MAX)
         $display("%0t: %s", $realtime, what);
      mismatches++;
   endtask

   initial begin
      mismatches   = 0;
      samples_owed = 0;
   end

   always @(posedge clock) begin
      value_type want;
      if (reset) begin
         generator_state = value_type'(1);
         foreach (shuffle_store[i])
            shuffle_store[i] = '0;
         last_pick = '0;
         expected_samples.delete();
      end else begin
         if (req_valid && req_ready)
            expected_samples.push_back(draw_sample(req_func, req_seed));
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               log_failure($sformatf("sample %0d with no draw outstanding", rsp_sample));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want)
                  log_failure($sformatf("sample mismatch: expected %0d, got %0d",
                                        want, rsp_sample));
            end
         end
      end
      samples_owed = expected_samples.size();
   end

endmodule

@@ tb/tb_shuffled_lehmer_random_generator_top.sv @@
// tb_shuffled_lehmer_random_generator_top: clock, reset and draw/reseed stimulus for the generator
// depends on slrg_pkg, shuffled_lehmer_random_generator_top and slrg_draw_checker
module tb_shuffled_lehmer_random_generator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import slrg_pkg::*;

   localparam int   ITEM_COUNT   = 2000;
   localparam int   IDLE_PERCENT = 12;
   localparam int   STALL_LIMIT  = 5000;
   localparam int   DRAIN_CYCLES = 20;
   localparam int   QUIET_FIRST  = 900;
   localparam int   QUIET_LAST   = 1199;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_func  = FUNC_DRAW;
   value_type req_seed  = '0;
   logic      rsp_ready = 1'b0;
   logic      req_ready;
   logic      rsp_valid;
   value_type rsp_sample;
   logic      quiet     = 1'b0;
   int        mismatches;
   int        samples_owed;
   int        stalled_cycles;

   shuffled_lehmer_random_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_seed   (req_seed),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

   slrg_draw_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_seed     (req_seed),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample),
      .mismatches   (mismatches),
      .samples_owed (samples_owed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // one transfer on the request channel; ready is looked at mid-cycle, once the block has settled
   task automatic send_request(logic func, value_type seed_value);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_seed  <= seed_value;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      do @(negedge clock); while (samples_owed != 0);
      @(posedge clock);
   endtask

   function automatic value_type random_seed();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return value_type'($urandom_range(255));
         default: return value_type'($urandom);
      endcase
   endfunction

   // watchdog: cycles with no transfer on either channel
   initial begin
      stalled_cycles = 0;
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("shuffled_lehmer_random_generator_top test failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first draw after reset seeds itself with one
      send_request(FUNC_DRAW, value_type'($urandom));
      send_request(FUNC_DRAW, '0);
      send_request(FUNC_DRAW, '1);
      send_request(FUNC_RESEED, '0);
      send_request(FUNC_DRAW, '0);
      send_request(FUNC_RESEED, value_type'(1));
      send_request(FUNC_DRAW, '0);
      // all-ones seed sticks the generator at zero, the next plain draw reseeds with one
      send_request(FUNC_RESEED, '1);
      send_request(FUNC_DRAW, '1);
      send_request(FUNC_DRAW, '0);
      send_request(FUNC_RESEED, value_type'(31'h7FFF_FFFE));
      send_request(FUNC_RESEED, value_type'(31'h4000_0000));
      send_request(FUNC_RESEED, value_type'(31'h5555_5555));
      send_request(FUNC_DRAW, value_type'(31'h2AAA_AAAA));
      send_request(FUNC_RESEED, value_type'(31'h2AAA_AAAA));
      send_request(FUNC_RESEED, value_type'(31'h2AAA_AAAA));
      repeat (8) send_request(FUNC_DRAW, value_type'($urandom));
      drain_samples();

      for (int n = 0; n < ITEM_COUNT; n++) begin
         quiet <= (n >= QUIET_FIRST && n <= QUIET_LAST);
         if (n == ITEM_COUNT / 2)
            drain_samples();
         if ($urandom_range(31) == 0)
            send_request(FUNC_RESEED, random_seed());
         else
            send_request(FUNC_DRAW, value_type'($urandom));
      end
      req_valid <= 1'b0;
      quiet     <= 1'b0;

      do @(negedge clock); while (samples_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && samples_owed == 0)
         $display("shuffled_lehmer_random_generator_top test passed");
      else
         $display("shuffled_lehmer_random_generator_top test failed");
      $finish;
   end

endmodule
